// File: hdl/traffic_loop_occupancy_tracker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the loop occupancy tracker
// Clocked property checks, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_LOOP_OCCUPANCY_TRACKER_ASSERT_SVH
`define TRAFFIC_LOOP_OCCUPANCY_TRACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property checked at every rising edge outside reset
`define TLOT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication from a trigger to a condition in the following cycle
`define TLOT_ASSERT_NEXT(name, clk, rst_n, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);
`else
`define TLOT_ASSERT(name, clk, rst_n, prop, msg)
`define TLOT_ASSERT_NEXT(name, clk, rst_n, trig, cond, msg)
`endif

`endif

// File: hdl/tlot_pkg.sv
// ----------------------------------------------------------------------------
// tlot_pkg
// Types and constants shared by the loop occupancy tracker modules.
// ----------------------------------------------------------------------------
package tlot_pkg;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 120;
    localparam int TUSER_W     = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [7:0]  COUNT_MAX   = 8'hFF;
    localparam logic [15:0] TICKS_MAX   = 16'hFFFF;
    localparam logic [15:0] ACCUM_STEP  = 16'd10;
    localparam logic [15:0] Q15_ONE     = 16'h8000;

    localparam logic [15:0] ALPHA_RESET  = 16'd8192;
    localparam logic [15:0] GAP_LIM_RST  = 16'd600;
    localparam logic [15:0] PERIOD_RESET = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_RISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_FALL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS  = 2'd3;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_STATUS = 2'd2
    } t_mode;

    typedef struct packed {
        logic [15:0] alpha_rise;
        logic [15:0] alpha_fall;
        logic [15:0] gap_limit;
        logic [15:0] period_ms;
    } t_cfg;

    typedef struct packed {
        t_mode       mode;
        logic        occupied_in;
        logic [39:0] time_ms;
        logic [7:0]  quality_in;
        logic [15:0] error_in;
    } t_item;

    // MSB first: packs to tdata with occupied_now in bit 0
    typedef struct packed {
        logic [15:0] error_out;
        logic [7:0]  quality_out;
        logic [15:0] smoothed_occupancy;
        logic [15:0] occupancy;
        logic [15:0] occupied_ticks;
        logic [15:0] last_gap_ticks;
        logic [15:0] gap_ticks;
        logic [7:0]  vehicle_count;
        logic        occupied_now;
    } t_result;

endpackage

// File: hdl/tlot_cfg.sv
// ----------------------------------------------------------------------------
// tlot_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module tlot_cfg
    import tlot_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha_rise <= ALPHA_RESET;
            r_cfg.alpha_fall <= ALPHA_RESET;
            r_cfg.gap_limit  <= GAP_LIM_RST;
            r_cfg.period_ms  <= PERIOD_RESET;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_ALPHA_RISE: r_cfg.alpha_rise <= i_cfg_wdata;
                CFG_ALPHA_FALL: r_cfg.alpha_fall <= i_cfg_wdata;
                CFG_GAP_LIMIT:  r_cfg.gap_limit  <= i_cfg_wdata;
                CFG_PERIOD_MS:  r_cfg.period_ms  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/tlot_smooth.sv
// ----------------------------------------------------------------------------
// tlot_smooth
// Q1.15 exponential smoothing step with rise/fall weight selection.
// ----------------------------------------------------------------------------
module tlot_smooth
    import tlot_pkg::*;
(
    input  logic [15:0] i_alpha_rise,
    input  logic [15:0] i_alpha_fall,
    input  logic [15:0] i_occ_prev,
    input  logic [15:0] i_smooth_prev,
    input  logic [15:0] i_occ_new,
    output logic [15:0] o_smooth_new
);

    logic [15:0] alpha_sel;
    logic [15:0] alpha;
    logic [15:0] keep_w;
    logic [31:0] prod_keep;
    logic [31:0] prod_new;
    logic [32:0] acc;

    always_comb begin
        alpha_sel = (i_occ_prev > i_smooth_prev) ? i_alpha_rise : i_alpha_fall;
        alpha     = (alpha_sel > Q15_ONE) ? Q15_ONE : alpha_sel;
        keep_w    = Q15_ONE - alpha;
        prod_keep = i_smooth_prev * keep_w;
        prod_new  = i_occ_new * alpha;
        acc       = {1'b0, prod_keep} + {1'b0, prod_new};
    end

    // truncating shift, low 16 bits kept
    assign o_smooth_new = acc[30:15];

endmodule

// File: hdl/tlot_core.sv
// ----------------------------------------------------------------------------
// tlot_core
// Detector state and its update for one request, registered when the request fires.
// ----------------------------------------------------------------------------
`include "traffic_loop_occupancy_tracker_assert.svh"

module tlot_core
    import tlot_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_next
);

    logic        r_occ_flag,   n_occ_flag;
    logic [7:0]  r_count,      n_count;
    logic [15:0] r_gap,        n_gap;
    logic [15:0] r_last_gap,   n_last_gap;
    logic [15:0] r_occ_time,   n_occ_time;
    logic [15:0] r_accum,      n_accum;
    logic [15:0] r_occ,        n_occ;
    logic [15:0] r_smooth,     n_smooth;
    logic [39:0] r_last_calc,  n_last_calc;
    logic [7:0]  r_quality,    n_quality;
    logic [15:0] r_error,      n_error;

    logic [16:0] accum_sum;
    logic [15:0] accum_tick;
    logic [39:0] elapsed;
    logic        period_due;
    logic [15:0] smooth_new;

    tlot_smooth u_smooth (
        .i_alpha_rise  (i_cfg.alpha_rise),
        .i_alpha_fall  (i_cfg.alpha_fall),
        .i_occ_prev    (r_occ),
        .i_smooth_prev (r_smooth),
        .i_occ_new     (accum_tick),
        .o_smooth_new  (smooth_new)
    );

    always_comb begin
        accum_sum  = {1'b0, r_accum} + {1'b0, ACCUM_STEP};
        accum_tick = r_occ_flag ? (accum_sum[16] ? TICKS_MAX : accum_sum[15:0]) : r_accum;
        elapsed    = i_item.time_ms - r_last_calc;
        period_due = (elapsed >= {24'd0, i_cfg.period_ms});

        n_occ_flag  = r_occ_flag;
        n_count     = r_count;
        n_gap       = r_gap;
        n_last_gap  = r_last_gap;
        n_occ_time  = r_occ_time;
        n_accum     = r_accum;
        n_occ       = r_occ;
        n_smooth    = r_smooth;
        n_last_calc = r_last_calc;
        n_quality   = r_quality;
        n_error     = r_error;

        case (i_item.mode)
            MODE_SAMPLE: begin
                if (!r_occ_flag && i_item.occupied_in) begin
                    n_count    = (r_count != COUNT_MAX) ? r_count + 8'd1 : r_count;
                    n_last_gap = r_gap;
                    n_gap      = '0;
                end
                n_occ_flag = i_item.occupied_in;
            end
            MODE_TICK: begin
                if (!r_occ_flag) begin
                    if (r_gap < i_cfg.gap_limit) begin
                        n_gap = r_gap + 16'd1;
                    end else begin
                        n_last_gap = r_gap;
                    end
                end else begin
                    n_occ_time = (r_occ_time != TICKS_MAX) ? r_occ_time + 16'd1 : r_occ_time;
                end
                n_accum = accum_tick;
                if (period_due) begin
                    n_smooth    = smooth_new;
                    n_occ       = accum_tick;
                    n_accum     = '0;
                    n_last_calc = i_item.time_ms;
                end
            end
            MODE_STATUS: begin
                n_quality = i_item.quality_in;
                n_error   = i_item.error_in;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ_flag  <= 1'b0;
            r_count     <= '0;
            r_gap       <= '0;
            r_last_gap  <= '0;
            r_occ_time  <= '0;
            r_accum     <= '0;
            r_occ       <= '0;
            r_smooth    <= '0;
            r_last_calc <= '0;
            r_quality   <= '0;
            r_error     <= '0;
        end else if (i_fire) begin
            r_occ_flag  <= n_occ_flag;
            r_count     <= n_count;
            r_gap       <= n_gap;
            r_last_gap  <= n_last_gap;
            r_occ_time  <= n_occ_time;
            r_accum     <= n_accum;
            r_occ       <= n_occ;
            r_smooth    <= n_smooth;
            r_last_calc <= n_last_calc;
            r_quality   <= n_quality;
            r_error     <= n_error;
        end
    end

    always_comb begin
        o_next.occupied_now       = n_occ_flag;
        o_next.vehicle_count      = n_count;
        o_next.gap_ticks          = n_gap;
        o_next.last_gap_ticks     = n_last_gap;
        o_next.occupied_ticks     = n_occ_time;
        o_next.occupancy          = n_occ;
        o_next.smoothed_occupancy = n_smooth;
        o_next.quality_out        = n_quality;
        o_next.error_out          = n_error;
    end

    `TLOT_ASSERT(a_count_monotonic, i_clk, i_rst_n, 1'b1 |=> (r_count >= $past(r_count)), "vehicle count decreased")
    `TLOT_ASSERT_NEXT(a_gap_clear_on_edge, i_clk, i_rst_n, i_fire && (i_item.mode == MODE_SAMPLE) && !r_occ_flag && i_item.occupied_in, r_gap == '0, "gap not cleared on rising edge")
    `TLOT_ASSERT(a_accum_clear_on_calc, i_clk, i_rst_n, !$stable(r_last_calc) |-> (r_accum == '0), "accumulator kept after period computation")

endmodule

// File: hdl/traffic_loop_occupancy_tracker.sv
// ----------------------------------------------------------------------------
// traffic_loop_occupancy_tracker
// Occupancy, gap and smoothing tracker for one vehicle loop detector.
// ----------------------------------------------------------------------------
// Path: a request is registered in the input reg, then its result in the result reg.
// Throughput: one request per cycle while m_axis_tready is high; state update is a single pass of the core.
// A stalled result is held while one further request is taken into the input reg.
// Reset (synchronous, active low) clears the valid flags and core state and loads config defaults.
module traffic_loop_occupancy_tracker
    import tlot_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] occupied_in, [40:1] time_ms, [48:41] quality_in, [64:49] error_in
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] mode
    input  logic [TUSER_W-1:0]     s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] occupied_now, [8:1] vehicle_count, [24:9] gap_ticks,
    // [40:25] last_gap_ticks, [56:41] occupied_ticks, [72:57] occupancy,
    // [88:73] smoothed_occupancy, [96:89] quality_out, [112:97] error_out
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_cfg    cfg;
    t_item   r_item;
    t_result core_next;
    t_result r_out;
    logic    r_in_vld;
    logic    r_out_vld;
    logic    s_acc;
    logic    fire;

    tlot_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign fire          = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || fire;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_acc) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_item.mode        <= t_mode'(s_axis_tuser);
            r_item.occupied_in <= s_axis_tdata[0];
            r_item.time_ms     <= s_axis_tdata[40:1];
            r_item.quality_in  <= s_axis_tdata[48:41];
            r_item.error_in    <= s_axis_tdata[64:49];
        end
        if (fire) begin
            r_out <= core_next;
        end
    end

    tlot_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_next  (core_next)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(OUT_TDATA_W - $bits(t_result))'(0), r_out};

endmodule
